// ----- hdl/csvtok_pkg.sv -----
// Types, character codes and result codes shared by the CSV line tokenizer.
package csvtok_pkg;

  // Fixed line-control characters
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // Result kinds
  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_FEND = 2'd1;
  localparam logic [1:0] K_LEND = 2'd2;
  localparam logic [1:0] K_ERR  = 2'd3;

  // Line-end status codes
  localparam logic [1:0] LS_OK         = 2'd0;
  localparam logic [1:0] LS_BARE_CR    = 2'd1;
  localparam logic [1:0] LS_OPEN_QUOTE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SEPARATOR = 1'b0;
  localparam logic CFG_QUOTE     = 1'b1;

  // Register reset values
  localparam logic [7:0] SEPARATOR_RST = 8'd44;
  localparam logic [7:0] QUOTE_RST     = 8'd34;

  // Input beat
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       field_null;
    logic [1:0] line_status;
    logic       last;
  } out_t;

  // Parser state, one-hot
  typedef enum logic [6:0] {
    S_LINE   = 7'b0000001,
    S_FIELD  = 7'b0000010,
    S_UNQ    = 7'b0000100,
    S_QUOTED = 7'b0001000,
    S_QSEEN  = 7'b0010000,
    S_CR     = 7'b0100000,
    S_SKIP   = 7'b1000000
  } pstate_t;

  // Build one result with last cleared
  function automatic out_t mk_res(logic [1:0] k, logic [7:0] b, logic nul, logic [1:0] st);
    out_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.field_null  = nul;
    r.line_status = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ----- hdl/csv_line_tokenizer.sv -----
// CSV line tokenizer: input register, parse logic and a three-entry result buffer.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------
//   in      | in_valid / in_stall | in_data  (cmd, in_byte)
//   out     | out_valid/out_stall | out_data (kind, out_byte, field_null,
//           |                     |           line_status, last)
//   cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An accepted beat waits in the input register until the result buffer can take
// its results (zero to three), which appear on out in the next cycle. The buffer
// sends one beat per cycle unless out_stall is high, so the block takes one input
// beat per cycle if each item makes at most one result; a larger group makes the next item wait.
// Reset (rst_n low, synchronous) returns the parser to line start and the
// separator and quote registers to ',' and '"'. out_stall holds the buffer; with
// two or more beats pending, or one pending beat under out_stall, the next item
// waits in the input register and in_stall rises.
module csv_line_tokenizer
  import csvtok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] sep_r;
  logic [7:0] quote_r;
  logic       in_vld_r;
  in_t        in_r;
  pstate_t    state_r;
  pstate_t    state_nxt;
  out_t       buf_r [3];
  out_t       res_nxt [3];
  logic [1:0] cnt_r;
  logic [1:0] n_nxt;
  logic       pop;
  logic       proc_go;

  // Start-of-field decode
  out_t       sf0;
  out_t       sf1;
  logic [1:0] sf_n;
  pstate_t    sf_st;
  logic [7:0] b;

  assign cfg_ready = 1'b1;
  assign b         = in_r.in_byte;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[0];
  assign pop       = out_valid && !out_stall;
  assign proc_go   = in_vld_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall));
  assign in_stall  = in_vld_r && !proc_go;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= SEPARATOR_RST;
      quote_r <= QUOTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEPARATOR: sep_r   <= cfg_data;
        CFG_QUOTE:     quote_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Hold the input beat until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Decode the first byte of a field
  always_comb begin
    sf0   = mk_res(K_BYTE, 8'd0, 1'b0, LS_OK);
    sf1   = mk_res(K_BYTE, 8'd0, 1'b0, LS_OK);
    sf_n  = 2'd0;
    sf_st = S_UNQ;
    if (b == quote_r) begin
      sf_st = S_QUOTED;
    end else if (b == CH_CR) begin
      sf0   = mk_res(K_FEND, 8'd0, 1'b1, LS_OK);
      sf_n  = 2'd1;
      sf_st = S_CR;
    end else if (b == CH_LF) begin
      sf0   = mk_res(K_FEND, 8'd0, 1'b1, LS_OK);
      sf1   = mk_res(K_LEND, 8'd0, 1'b0, LS_OK);
      sf_n  = 2'd2;
      sf_st = S_LINE;
    end else if (b == sep_r) begin
      sf0   = mk_res(K_FEND, 8'd0, 1'b1, LS_OK);
      sf_n  = 2'd1;
      sf_st = S_FIELD;
    end else begin
      sf0   = mk_res(K_BYTE, b, 1'b0, LS_OK);
      sf_n  = 2'd1;
      sf_st = S_UNQ;
    end
  end

  // Parse one beat: results and next state
  always_comb begin
    res_nxt[0] = mk_res(K_BYTE, 8'd0, 1'b0, LS_OK);
    res_nxt[1] = mk_res(K_BYTE, 8'd0, 1'b0, LS_OK);
    res_nxt[2] = mk_res(K_BYTE, 8'd0, 1'b0, LS_OK);
    n_nxt      = 2'd0;
    state_nxt  = state_r;
    if (in_r.cmd) begin
      // End of input: close whatever is open, then back to line start
      state_nxt = S_LINE;
      case (state_r)
        S_FIELD: begin
          res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b1, LS_OK);
          res_nxt[1] = mk_res(K_LEND, 8'd0, 1'b0, LS_OK);
          n_nxt      = 2'd2;
        end
        S_UNQ, S_QSEEN: begin
          res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
          res_nxt[1] = mk_res(K_LEND, 8'd0, 1'b0, LS_OK);
          n_nxt      = 2'd2;
        end
        S_QUOTED: begin
          res_nxt[0] = mk_res(K_LEND, 8'd0, 1'b0, LS_OPEN_QUOTE);
          n_nxt      = 2'd1;
        end
        S_CR: begin
          res_nxt[0] = mk_res(K_LEND, 8'd0, 1'b0, LS_BARE_CR);
          n_nxt      = 2'd1;
        end
        default: ;
      endcase
    end else begin
      case (state_r)
        S_LINE, S_FIELD: begin
          res_nxt[0] = sf0;
          res_nxt[1] = sf1;
          n_nxt      = sf_n;
          state_nxt  = sf_st;
        end
        S_UNQ: begin
          if (b == CH_CR) begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd1;
            state_nxt  = S_CR;
          end else if (b == CH_LF) begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            res_nxt[1] = mk_res(K_LEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd2;
            state_nxt  = S_LINE;
          end else if (b == sep_r) begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd1;
            state_nxt  = S_FIELD;
          end else begin
            res_nxt[0] = mk_res(K_BYTE, b, 1'b0, LS_OK);
            n_nxt      = 2'd1;
          end
        end
        S_QUOTED: begin
          if (b == quote_r) begin
            state_nxt = S_QSEEN;
          end else begin
            res_nxt[0] = mk_res(K_BYTE, b, 1'b0, LS_OK);
            n_nxt      = 2'd1;
          end
        end
        S_QSEEN: begin
          if (b == quote_r) begin
            // Doubled quote gives one quote byte
            res_nxt[0] = mk_res(K_BYTE, b, 1'b0, LS_OK);
            n_nxt      = 2'd1;
            state_nxt  = S_QUOTED;
          end else if (b == CH_CR) begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd1;
            state_nxt  = S_CR;
          end else if (b == CH_LF) begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            res_nxt[1] = mk_res(K_LEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd2;
            state_nxt  = S_LINE;
          end else if (b == sep_r) begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd1;
            state_nxt  = S_FIELD;
          end else begin
            res_nxt[0] = mk_res(K_FEND, 8'd0, 1'b0, LS_OK);
            res_nxt[1] = mk_res(K_ERR, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd2;
            state_nxt  = S_SKIP;
          end
        end
        S_CR: begin
          if (b == CH_LF) begin
            res_nxt[0] = mk_res(K_LEND, 8'd0, 1'b0, LS_OK);
            n_nxt      = 2'd1;
            state_nxt  = S_LINE;
          end else begin
            // Bare CR: close the line, then this byte starts a new one
            res_nxt[0] = mk_res(K_LEND, 8'd0, 1'b0, LS_BARE_CR);
            res_nxt[1] = sf0;
            res_nxt[2] = sf1;
            n_nxt      = sf_n + 2'd1;
            state_nxt  = sf_st;
          end
        end
        default: begin
          // Discard up to the next LF
          if (b == CH_LF) begin
            state_nxt = S_LINE;
          end else begin
            state_nxt = S_SKIP;
          end
        end
      endcase
    end
    // Flag the final result of this beat
    res_nxt[0].last = (n_nxt == 2'd1);
    res_nxt[1].last = (n_nxt == 2'd2);
    res_nxt[2].last = (n_nxt == 2'd3);
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LINE;
    end else if (proc_go) begin
      state_r <= state_nxt;
    end
  end

  // Result buffer: load a new group or shift one beat out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (proc_go) begin
      cnt_r <= n_nxt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      buf_r[0] <= res_nxt[0];
      buf_r[1] <= res_nxt[1];
      buf_r[2] <= res_nxt[2];
    end else if (pop) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

endmodule
